>>> rtl/wpf_pkg.sv
// Package with shared types and constants for the waypoint follower.
`timescale 1ns / 1ps
`default_nettype none
package wpf_pkg;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_LOAD = 2'd1;
   localparam logic [1:0] CMD_SETPOS = 2'd2;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_SETPOS = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;

   localparam logic [1:0] CSR_STEP_TIME = 2'd0;
   localparam logic [1:0] CSR_SPEED = 2'd1;
   localparam logic [1:0] CSR_WP_COUNT = 2'd2;

   localparam logic [15:0] STEP_TIME_RST = 16'd655;
   localparam logic [23:0] SPEED_RST = 24'd65536;

   localparam int DT_BITS = 16;
   localparam int SQRT_STEPS = 25;
   localparam int DIV_STEPS = 24;
   localparam logic [39:0] FINE_MUL = 40'd1000;
   localparam logic [39:0] NEAR_MUL = 40'd10;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] entry_index;
      logic signed [23:0] coord_x;
      logic signed [23:0] coord_y;
      logic signed [23:0] coord_z;
   } item_type;

endpackage
`default_nettype wire

>>> rtl/wpf_front.sv
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none
module wpf_front #(
   parameter int MAX_WAYPOINTS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_command,
   input  wire logic [4:0]        req_entry_index,
   input  wire logic signed [23:0] req_coord_x,
   input  wire logic signed [23:0] req_coord_y,
   input  wire logic signed [23:0] req_coord_z,
   output logic                   q_valid,
   input  wire logic              q_ready,
   output wpf_pkg::item_type      q_item
);

   wpf_pkg::item_type slot_ff [2];
   wpf_pkg::item_type new_item;
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   always_comb begin
      new_item.entry_index = req_entry_index;
      new_item.coord_x = req_coord_x;
      new_item.coord_y = req_coord_y;
      new_item.coord_z = req_coord_z;
      case (req_command)
         wpf_pkg::CMD_TICK: new_item.op = wpf_pkg::OP_TICK;
         wpf_pkg::CMD_LOAD: new_item.op =
            (32'(req_entry_index) < MAX_WAYPOINTS) ? wpf_pkg::OP_LOAD : wpf_pkg::OP_NOP;
         wpf_pkg::CMD_SETPOS: new_item.op = wpf_pkg::OP_SETPOS;
         default: new_item.op = wpf_pkg::OP_NOP;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = slot_ff[rd_ptr_ff];
   assign push = req_valid && req_ready;
   assign pop = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

>>> rtl/wpf_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wpf_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [49:0] radicand,
   output logic             done,
   output logic [24:0]      root
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [49:0] rad_ff, rad_in;
   logic [27:0] rem_ff, rem_in;
   logic [24:0] root_ff, root_in;
   logic [27:0] rem_sh, trial;
   logic ge;

   always_comb begin
      rem_sh = {rem_ff[25:0], rad_ff[49:48]};
      trial = {1'b0, root_ff, 2'b01};
      ge = (rem_sh >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = 5'(wpf_pkg::SQRT_STEPS - 1);
         rad_in = radicand;
         rem_in = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - trial : rem_sh;
         root_in = {root_ff[23:0], ge};
         rad_in = {rad_ff[47:0], 2'b00};
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

>>> rtl/wpf_div.sv
// Restoring divider, one quotient bit per cycle; quotient must fit 24 bits.
`timescale 1ns / 1ps
`default_nettype none
module wpf_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] dividend,
   input  wire logic [24:0] divisor,
   output logic             done,
   output logic [23:0]      quotient
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [24:0] rem_ff, rem_in;
   logic [23:0] low_ff, low_in;
   logic [24:0] dvs_ff, dvs_in;
   logic [25:0] rem_sh, dvs_ext, diff;
   logic ge;

   always_comb begin
      rem_sh = {rem_ff, low_ff[23]};
      dvs_ext = {1'b0, dvs_ff};
      diff = rem_sh - dvs_ext;
      ge = (rem_sh >= dvs_ext);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      low_in = low_ff;
      dvs_in = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = 5'(wpf_pkg::DIV_STEPS - 1);
         rem_in = {1'b0, dividend[47:24]};
         low_in = dividend[23:0];
         dvs_in = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[24:0] : rem_sh[24:0];
         low_in = {low_ff[22:0], ge};
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = low_ff;

endmodule
`default_nettype wire

>>> rtl/wpf_back.sv
// Back end: route state, waypoint memory, guidance sequencer and response register.
`timescale 1ns / 1ps
`default_nettype none
module wpf_back #(
   parameter int MAX_WAYPOINTS = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [23:0]       csr_wdata,
   input  wire logic              q_valid,
   output logic                   q_ready,
   input  wire wpf_pkg::item_type q_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic signed [23:0]     rsp_pos_x,
   output logic signed [23:0]     rsp_pos_y,
   output logic signed [23:0]     rsp_pos_z,
   output logic [5:0]             rsp_route_index,
   output logic                   rsp_route_done
);

   localparam int IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_READ = 4'd1;
   localparam logic [3:0] S_SQ = 4'd2;
   localparam logic [3:0] S_SQRT_GO = 4'd3;
   localparam logic [3:0] S_SQRT_WAIT = 4'd4;
   localparam logic [3:0] S_MUL = 4'd5;
   localparam logic [3:0] S_DIV_GO = 4'd6;
   localparam logic [3:0] S_DIV_WAIT = 4'd7;
   localparam logic [3:0] S_MOVE = 4'd8;
   localparam logic [3:0] S_UPD = 4'd9;
   localparam logic [3:0] S_RESP = 4'd10;

   localparam logic [39:0] ONE = 40'd1 << FRAC_BITS;

   logic [71:0] tbl_mem [MAX_WAYPOINTS];
   logic [71:0] rd_ff;
   logic mem_we;

   logic [3:0] state_ff, state_in;
   logic signed [23:0] pos_ff [3];
   logic signed [23:0] pos_in [3];
   logic [5:0] idx_ff, idx_in;
   logic [15:0] step_time_ff, step_time_in;
   logic [23:0] speed_ff, speed_in;
   logic [5:0] count_ff, count_in;
   logic [2:0] neg_ff, neg_in;
   logic [23:0] mag_ff [3];
   logic [23:0] mag_in [3];
   logic [2:0] small_ff, small_in;
   logic near_ff, near_in;
   logic [49:0] sum_ff, sum_in;
   logic [1:0] ax_ff, ax_in;
   logic [24:0] norm_ff, norm_in;
   logic [47:0] prod_ff, prod_in;
   logic [23:0] vmag_ff, vmag_in;
   logic [23:0] move_ff, move_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] rsp_pos_ff [3];
   logic signed [23:0] rsp_pos_in [3];
   logic [5:0] rsp_idx_ff, rsp_idx_in;
   logic rsp_done_ff, rsp_done_in;

   logic sqrt_start, sqrt_done, div_start, div_done;
   logic [24:0] sqrt_root;
   logic [23:0] div_quot;
   logic [5:0] eff_count;
   logic route_done_now;
   logic [47:0] sq;
   logic [39:0] mv;
   logic signed [24:0] dsum;
   logic signed [25:0] pbase, pnext;

   wpf_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .radicand(sum_ff),
      .done(sqrt_done), .root(sqrt_root)
   );

   wpf_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(prod_ff),
      .divisor(norm_ff), .done(div_done), .quotient(div_quot)
   );

   assign eff_count = (32'(count_ff) > MAX_WAYPOINTS) ? 6'(MAX_WAYPOINTS) : count_ff;
   assign route_done_now = (idx_ff >= eff_count);

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      step_time_in = step_time_ff;
      speed_in = speed_ff;
      count_in = count_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      small_in = small_ff;
      near_in = near_ff;
      sum_in = sum_ff;
      ax_in = ax_ff;
      norm_in = norm_ff;
      prod_in = prod_ff;
      vmag_in = vmag_ff;
      move_in = move_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pos_in = rsp_pos_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_done_in = rsp_done_ff;
      q_ready = 1'b0;
      mem_we = 1'b0;
      sqrt_start = 1'b0;
      div_start = 1'b0;
      sq = 48'(mag_ff[ax_ff]) * 48'(mag_ff[ax_ff]);
      mv = 40'(vmag_ff) * 40'(step_time_ff);
      dsum = '0;
      pbase = 26'(pos_ff[ax_ff]);
      pnext = neg_ff[ax_ff] ? pbase - $signed(26'(move_ff)) : pbase + $signed(26'(move_ff));

      if (csr_we) begin
         case (csr_index)
            wpf_pkg::CSR_STEP_TIME: step_time_in = csr_wdata[15:0];
            wpf_pkg::CSR_SPEED: speed_in = csr_wdata;
            wpf_pkg::CSR_WP_COUNT: count_in = csr_wdata[5:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               case (q_item.op)
                  wpf_pkg::OP_TICK: state_in = route_done_now ? S_RESP : S_READ;
                  wpf_pkg::OP_LOAD: begin
                     mem_we = 1'b1;
                     state_in = S_RESP;
                  end
                  wpf_pkg::OP_SETPOS: begin
                     pos_in[0] = q_item.coord_x;
                     pos_in[1] = q_item.coord_y;
                     pos_in[2] = q_item.coord_z;
                     idx_in = '0;
                     state_in = S_RESP;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_READ: begin
            for (int a = 0; a < 3; a++) begin
               dsum = 25'($signed(rd_ff[(2 - a) * 24 +: 24])) - 25'(pos_ff[a]);
               neg_in[a] = dsum[24];
               mag_in[a] = dsum[24] ? 24'(-dsum) : 24'(dsum);
            end
            sum_in = '0;
            near_in = 1'b1;
            ax_in = '0;
            state_in = S_SQ;
         end
         S_SQ: begin
            sum_in = sum_ff + 50'(sq);
            if (40'(mag_ff[ax_ff]) * wpf_pkg::NEAR_MUL >= ONE) begin
               near_in = 1'b0;
            end
            small_in[ax_ff] = (40'(mag_ff[ax_ff]) * wpf_pkg::FINE_MUL < ONE);
            if (ax_ff == 2'd2) begin
               ax_in = '0;
               state_in = S_SQRT_GO;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         S_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (sqrt_done) begin
               norm_in = sqrt_root;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = 48'(mag_ff[ax_ff]) * 48'(speed_ff);
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               vmag_in = (small_ff[ax_ff] || norm_ff == '0) ? '0 : div_quot;
               state_in = S_MOVE;
            end
         end
         S_MOVE: begin
            move_in = mv[wpf_pkg::DT_BITS +: 24];
            state_in = S_UPD;
         end
         S_UPD: begin
            if (pnext > 26'sd8388607) begin
               pos_in[ax_ff] = 24'sh7FFFFF;
            end else if (pnext < -26'sd8388608) begin
               pos_in[ax_ff] = 24'sh800000;
            end else begin
               pos_in[ax_ff] = pnext[23:0];
            end
            if (ax_ff == 2'd2) begin
               if (near_ff) begin
                  idx_in = idx_ff + 6'd1;
               end
               state_in = S_RESP;
            end else begin
               ax_in = ax_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in = pos_ff;
               rsp_idx_in = idx_ff;
               rsp_done_in = route_done_now;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[IW'(q_item.entry_index)] <= {q_item.coord_x, q_item.coord_y, q_item.coord_z};
      end
      rd_ff <= tbl_mem[IW'(idx_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff <= '{default: '0};
         idx_ff <= '0;
         step_time_ff <= wpf_pkg::STEP_TIME_RST;
         speed_ff <= wpf_pkg::SPEED_RST;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         idx_ff <= idx_in;
         step_time_ff <= step_time_in;
         speed_ff <= speed_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      small_ff <= small_in;
      near_ff <= near_in;
      sum_ff <= sum_in;
      ax_ff <= ax_in;
      norm_ff <= norm_in;
      prod_ff <= prod_in;
      vmag_ff <= vmag_in;
      move_ff <= move_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = rsp_pos_ff[0];
   assign rsp_pos_y = rsp_pos_ff[1];
   assign rsp_pos_z = rsp_pos_ff[2];
   assign rsp_route_index = rsp_idx_ff;
   assign rsp_route_done = rsp_done_ff;

endmodule
`default_nettype wire

>>> rtl/waypoint_follower_unit.sv
// Waypoint follower top level: request queue, guidance back end and checks.
// Usage:
//   req_* carries one request: command 0 ticks the guidance, command 1 loads
//   waypoint entry req_entry_index, command 2 sets the position and restarts
//   the route. Every request yields exactly one response on rsp_*, in order,
//   holding the position, route index and route-done flag after the request.
//   csr_we/csr_index/csr_wdata write step_time (0), speed (1) and
//   waypoint_count (2); write only while no request is outstanding.
// Sequence: load, set-position, unused commands and ticks on a finished route
//   go from the queue through the response state to the response register. A
//   moving tick reads its waypoint, sums the squares, runs the 25-step square
//   root, then per axis a 24-step division on the single shared divider, three in all.
// Flow: one request at a time in the back end, which takes the next request
//   only after the response of the last one is registered; a two-entry queue in
//   front accepts requests while the back end works.
// Reset: position and route index clear, registers return to step_time 655,
//   speed 1.0, waypoint_count 0; waypoint entries are undefined until loaded.
// A stalled receiver holds the response register; the back end then waits
//   and the queue fills, after which req_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module waypoint_follower_unit #(
   parameter int MAX_WAYPOINTS = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [23:0]       csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_command,
   input  wire logic [4:0]        req_entry_index,
   input  wire logic signed [23:0] req_coord_x,
   input  wire logic signed [23:0] req_coord_y,
   input  wire logic signed [23:0] req_coord_z,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic signed [23:0]     rsp_pos_x,
   output logic signed [23:0]     rsp_pos_y,
   output logic signed [23:0]     rsp_pos_z,
   output logic [5:0]             rsp_route_index,
   output logic                   rsp_route_done
);

   logic q_valid, q_ready;
   wpf_pkg::item_type q_item;

   wpf_front #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_entry_index(req_entry_index), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   wpf_back #(.MAX_WAYPOINTS(MAX_WAYPOINTS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_route_index(rsp_route_index), .rsp_route_done(rsp_route_done)
   );

   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_full_queue_presents: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("request queue full but presents no item");

   a_index_in_table: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_route_done) |-> (32'(rsp_route_index) < MAX_WAYPOINTS))
      else $error("active route index beyond waypoint table");

   a_load_in_range: assert property (@(posedge clock) disable iff (reset)
      (q_valid && q_ready && q_item.op == wpf_pkg::OP_LOAD)
         |-> (32'(q_item.entry_index) < MAX_WAYPOINTS))
      else $error("waypoint load beyond table");

endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the waypoint follower: random requests, route phases, scoreboard.
`timescale 1ns / 1ps
module tb;

   localparam int LIMIT = 3000000;
   localparam int TABLE_SIZE = 32;
   localparam int SETTLE = 200;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic [5:0] route_index;
      logic route_done;
   } rsp_type;

   logic clock, reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [23:0] csr_wdata;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   wpf_pkg::item_type cur_item;
   logic signed [23:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [5:0] rsp_route_index;
   logic rsp_route_done;

   wpf_pkg::item_type pending_reqs[$];
   rsp_type expected_rsps[$];

   // guidance state mirror
   logic signed [23:0] mdl_pos[3] = '{default: '0};
   logic signed [23:0] mdl_wp[TABLE_SIZE][3] = '{default: '0};
   logic [5:0] mdl_index = '0;
   logic [15:0] mdl_step = wpf_pkg::STEP_TIME_RST;
   logic [23:0] mdl_speed = wpf_pkg::SPEED_RST;
   logic [5:0] mdl_count = '0;

   int errors = 0;
   int n_rsp = 0;
   int n_ticks = 0;
   int n_adv = 0;
   int n_done = 0;
   int cycles = 0;
   int send_gap, recv_stall;
   bit no_idle = 0;
   logic signed [23:0] route_wp[TABLE_SIZE][3];

   waypoint_follower_unit dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(cur_item.op), .req_entry_index(cur_item.entry_index),
      .req_coord_x(cur_item.coord_x), .req_coord_y(cur_item.coord_y),
      .req_coord_z(cur_item.coord_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_pos_z(rsp_pos_z),
      .rsp_route_index(rsp_route_index), .rsp_route_done(rsp_route_done)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint unsigned sqrt_floor(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic int route_len();
      return (mdl_count > TABLE_SIZE) ? TABLE_SIZE : int'(mdl_count);
   endfunction

   function automatic void guidance_tick();
      longint d[3];
      longint mag[3];
      longint sum, norm, vmag, mv, p;
      bit near_all;
      sum = 0;
      near_all = 1;
      if (int'(mdl_index) >= route_len()) return;
      n_ticks++;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'(mdl_wp[mdl_index][i]) - longint'(mdl_pos[i]);
         mag[i] = (d[i] < 0) ? -d[i] : d[i];
         sum += mag[i] * mag[i];
         if (mag[i] * 10 >= 65536) near_all = 0;
      end
      norm = longint'(sqrt_floor(sum));
      for (int i = 0; i < 3; i++) begin
         vmag = 0;
         if (mag[i] * 1000 >= 65536 && norm != 0)
            vmag = (mag[i] * longint'({40'd0, mdl_speed})) / norm;
         mv = (vmag * longint'({48'd0, mdl_step})) >>> wpf_pkg::DT_BITS;
         p = longint'(mdl_pos[i]) + ((d[i] < 0) ? -mv : mv);
         if (p > 8388607) p = 8388607;
         if (p < -8388608) p = -8388608;
         mdl_pos[i] = p[23:0];
      end
      if (near_all) begin
         mdl_index++;
         n_adv++;
      end
   endfunction

   function automatic rsp_type apply_request(wpf_pkg::item_type it);
      rsp_type r;
      case (it.op)
         wpf_pkg::CMD_TICK: guidance_tick();
         wpf_pkg::CMD_LOAD: begin
            mdl_wp[it.entry_index][0] = it.coord_x;
            mdl_wp[it.entry_index][1] = it.coord_y;
            mdl_wp[it.entry_index][2] = it.coord_z;
         end
         wpf_pkg::CMD_SETPOS: begin
            mdl_pos[0] = it.coord_x;
            mdl_pos[1] = it.coord_y;
            mdl_pos[2] = it.coord_z;
            mdl_index = 0;
         end
         default: ;
      endcase
      r.pos_x = mdl_pos[0];
      r.pos_y = mdl_pos[1];
      r.pos_z = mdl_pos[2];
      r.route_index = mdl_index;
      r.route_done = (int'(mdl_index) >= route_len());
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         cur_item <= '0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) expected_rsps.push_back(apply_request(cur_item));
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               cur_item <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (e.route_done) n_done++;
               if (rsp_pos_x !== e.pos_x) begin
                  $error("pos_x expected %0d got %0d", e.pos_x, rsp_pos_x); errors++;
               end
               if (rsp_pos_y !== e.pos_y) begin
                  $error("pos_y expected %0d got %0d", e.pos_y, rsp_pos_y); errors++;
               end
               if (rsp_pos_z !== e.pos_z) begin
                  $error("pos_z expected %0d got %0d", e.pos_z, rsp_pos_z); errors++;
               end
               if (rsp_route_index !== e.route_index) begin
                  $error("route_index expected %0d got %0d", e.route_index, rsp_route_index);
                  errors++;
               end
               if (rsp_route_done !== e.route_done) begin
                  $error("route_done expected %0d got %0d", e.route_done, rsp_route_done);
                  errors++;
               end
            end
         end
         if (recv_stall != 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            recv_stall <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send(logic [1:0] op, logic [4:0] idx,
                       logic signed [23:0] x, logic signed [23:0] y, logic signed [23:0] z);
      wpf_pkg::item_type it;
      it.op = op;
      it.entry_index = idx;
      it.coord_x = x;
      it.coord_y = y;
      it.coord_z = z;
      pending_reqs.push_back(it);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [23:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         wpf_pkg::CSR_STEP_TIME: mdl_step = data[15:0];
         wpf_pkg::CSR_SPEED: mdl_speed = data;
         wpf_pkg::CSR_WP_COUNT: mdl_count = data[5:0];
         default: ;
      endcase
   endtask

   function automatic logic signed [23:0] near(logic signed [23:0] c, int span);
      longint v;
      v = longint'(c) + $signed($urandom_range(0, 2 * span)) - span;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[23:0];
   endfunction

   localparam logic signed [23:0] CMAX = 24'sh7fffff;
   localparam logic signed [23:0] CMIN = 24'sh800000;

   initial begin
      int steps[8];
      int speeds[8];
      int counts[8];
      int r, n_items;
      logic [1:0] noise_op;
      steps = '{65535, 655, 0, 65535, 65535, 40000, 32768, 20000};
      speeds = '{6554, 65536, 100000, 16777215, 3277, 50000, 13107, 0};
      counts = '{6, 3, 32, 63, 10, 0, 40, 20};
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, finished route, unused command, saturation
      send(wpf_pkg::CMD_SETPOS, 5'd0, CMAX, CMAX, CMIN);
      send(wpf_pkg::CMD_TICK, 5'd0, '0, '0, '0);
      send(CMD_UNUSED, 5'd31, CMAX, CMIN, -24'sd1);
      send(wpf_pkg::CMD_LOAD, 5'd0, CMIN, CMIN, CMAX);
      send(wpf_pkg::CMD_LOAD, 5'd31, CMAX, CMIN, 24'sd0);
      send(wpf_pkg::CMD_LOAD, 5'd1, 24'sd0, 24'sd0, 24'sd0);
      send(wpf_pkg::CMD_LOAD, 5'd2, 24'sd65, 24'sd66, -24'sd6553);
      wait_idle();
      csr_write(wpf_pkg::CSR_STEP_TIME, 24'hffff);
      csr_write(wpf_pkg::CSR_SPEED, 24'hffffff);
      csr_write(wpf_pkg::CSR_WP_COUNT, 24'd3);
      for (int i = 0; i < 5; i++) send(wpf_pkg::CMD_TICK, 5'd0, '0, '0, '0);
      send(wpf_pkg::CMD_SETPOS, 5'd0, 24'sd0, 24'sd0, 24'sd0);
      for (int i = 0; i < 4; i++) send(wpf_pkg::CMD_TICK, 5'd0, '0, '0, '0);
      send(wpf_pkg::CMD_SETPOS, 5'd0, 24'sd0, 24'sd0, 24'sd10);
      send(wpf_pkg::CMD_TICK, 5'd0, '0, '0, '0);
      wait_idle();
      csr_write(wpf_pkg::CSR_WP_COUNT, 24'd1);
      send(wpf_pkg::CMD_TICK, 5'd0, '0, '0, '0);
      send(wpf_pkg::CMD_TICK, 5'd0, '0, '0, '0);

      for (int ph = 0; ph < 8; ph++) begin
         no_idle = (ph == 2 || ph == 6);
         route_wp[0][0] = near(24'sd0, 262144);
         route_wp[0][1] = near(24'sd0, 262144);
         route_wp[0][2] = near(24'sd0, 262144);
         for (int i = 1; i < TABLE_SIZE; i++)
            for (int j = 0; j < 3; j++) route_wp[i][j] = near(route_wp[i-1][j], 52428);
         for (int i = 0; i < TABLE_SIZE; i++)
            send(wpf_pkg::CMD_LOAD, i[4:0], route_wp[i][0], route_wp[i][1], route_wp[i][2]);
         wait_idle();
         csr_write(wpf_pkg::CSR_STEP_TIME, steps[ph][23:0]);
         csr_write(wpf_pkg::CSR_SPEED, speeds[ph][23:0]);
         csr_write(wpf_pkg::CSR_WP_COUNT,
                   (ph == 7) ? 24'($urandom_range(0, 63)) : counts[ph][23:0]);
         csr_write(CSR_UNUSED, 24'($urandom));
         send(wpf_pkg::CMD_SETPOS, 5'd0, near(route_wp[0][0], 65536),
              near(route_wp[0][1], 65536), near(route_wp[0][2], 65536));
         n_items = 0;
         while (n_items < 200) begin
            r = $urandom_range(0, 99);
            n_items++;
            if (r < 72) begin
               send(wpf_pkg::CMD_TICK, 5'($urandom), 24'($urandom), 24'($urandom),
                    24'($urandom));
            end else if (r < 80) begin
               send(wpf_pkg::CMD_SETPOS, 5'd0, near(route_wp[0][0], 65536),
                    near(route_wp[0][1], 65536), near(route_wp[0][2], 65536));
            end else if (r < 87) begin
               int k;
               k = $urandom_range(0, TABLE_SIZE - 1);
               send(wpf_pkg::CMD_LOAD, k[4:0], near(route_wp[k][0], 13107),
                    near(route_wp[k][1], 13107), near(route_wp[k][2], 13107));
            end else if (r < 92) begin
               send(wpf_pkg::CMD_SETPOS, 5'($urandom), 24'($urandom), 24'($urandom),
                    24'($urandom));
            end else if (r < 96) begin
               send(wpf_pkg::CMD_LOAD, 5'($urandom), 24'($urandom), 24'($urandom),
                    24'($urandom));
            end else begin
               noise_op = CMD_UNUSED;
               send(noise_op, 5'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
            end
            if (pending_reqs.size() > 8) begin
               while (pending_reqs.size() > 2) @(negedge clock);
            end
         end
      end

      wait_idle();
      $display("tb: %0d responses checked, %0d moving ticks, %0d waypoints reached", n_rsp,
               n_ticks, n_adv);
      $display("tb: %0d responses on a finished route, 8 register settings", n_done);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/wpf_pkg.sv
rtl/wpf_front.sv
rtl/wpf_sqrt.sv
rtl/wpf_div.sv
rtl/wpf_back.sv
rtl/waypoint_follower_unit.sv
verif/tb.sv
